// ===== sv/bmp24_pkg.sv =====
// Shared types and constants for the 24-bit BMP stream reader.
package bmp24_pkg;

    localparam int MAX_DIM_DEF = 4096;

    localparam logic [5:0]  HEADER_BYTES  = 6'd54;
    localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
    localparam logic [31:0] BMP_FORMAT    = 32'h0018_0001;

    // Byte offsets of the header fields in use
    localparam logic [5:0] SIG_END    = 6'd2;
    localparam logic [5:0] WIDTH_POS  = 6'd18;
    localparam logic [5:0] HEIGHT_POS = 6'd22;
    localparam logic [5:0] FORMAT_POS = 6'd26;
    localparam logic [5:0] FORMAT_END = 6'd30;

    typedef enum logic [2:0] {
        KIND_PIXEL     = 3'd0,
        KIND_HEADER_OK = 3'd1,
        KIND_BAD_SIG   = 3'd2,
        KIND_NOT_24BIT = 3'd3,
        KIND_BAD_SIZE  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_PIXEL  = 2'd1,
        PH_PAD    = 2'd2,
        PH_IDLE   = 2'd3
    } phase_t;

    typedef struct packed {
        kind_t       kind;
        logic [11:0] row;
        logic [11:0] column;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic        last_pixel;
        logic [12:0] image_width;
        logic [12:0] image_height;
    } result_t;

endpackage

// ===== sv/bmp24_parser.sv =====
// Header and pixel parser: state registers and the per-byte result logic.
module bmp24_parser #(
    parameter int MAX_DIM = bmp24_pkg::MAX_DIM_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    input  logic                file_start,
    output logic                res_valid,
    output bmp24_pkg::result_t  res
);

    localparam int CNT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam logic [31:0] MAX_WORD = 32'(MAX_DIM);

    bmp24_pkg::phase_t phase_reg, phase_next, cur_phase;
    logic [5:0]        hcount_reg, hcount_next, cur_hcount;
    logic [15:0]       sig_reg, sig_next, cur_sig;
    logic [31:0]       width_reg, width_next, cur_width;
    logic [31:0]       height_reg, height_next, cur_height;
    logic [31:0]       format_reg, format_next, cur_format;
    logic [1:0]        bip_reg, bip_next;
    logic [7:0]        blue_reg, blue_next;
    logic [7:0]        green_reg, green_next;
    logic [CNT_W-1:0]  col_reg, col_next;
    logic [CNT_W-1:0]  row_reg, row_next;
    logic [1:0]        pad_cnt_reg, pad_cnt_next;
    logic [1:0]        pad_amt_reg, pad_amt_next;

    logic [1:0]        w_off, h_off, f_off;
    logic [1:0]        pad_inc;
    logic              row_end, last;
    logic [31:0]       row_out;

    function automatic logic size_ok(input logic [31:0] v, input logic [31:0] lim);
        return (v != 32'd0) && (v <= lim);
    endfunction

    // A start flag makes this byte see the reset state
    assign cur_phase  = file_start ? bmp24_pkg::PH_HEADER : phase_reg;
    assign cur_hcount = file_start ? 6'd0  : hcount_reg;
    assign cur_sig    = file_start ? 16'd0 : sig_reg;
    assign cur_width  = file_start ? 32'd0 : width_reg;
    assign cur_height = file_start ? 32'd0 : height_reg;
    assign cur_format = file_start ? 32'd0 : format_reg;

    assign w_off = 2'(cur_hcount - bmp24_pkg::WIDTH_POS);
    assign h_off = 2'(cur_hcount - bmp24_pkg::HEIGHT_POS);
    assign f_off = 2'(cur_hcount - bmp24_pkg::FORMAT_POS);

    assign row_end = (32'(col_reg) + 32'd1) >= width_reg;
    assign last    = row_end && ((32'(row_reg) + 32'd1) >= height_reg);
    assign row_out = height_reg - 32'd1 - 32'(row_reg);
    assign pad_inc = pad_cnt_reg + 2'd1;

    always_comb
    begin
        phase_next   = cur_phase;
        hcount_next  = cur_hcount;
        sig_next     = cur_sig;
        width_next   = cur_width;
        height_next  = cur_height;
        format_next  = cur_format;
        bip_next     = bip_reg;
        blue_next    = blue_reg;
        green_next   = green_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        pad_cnt_next = pad_cnt_reg;
        pad_amt_next = pad_amt_reg;
        res_valid    = 1'b0;
        res          = '0;

        case (cur_phase)
            bmp24_pkg::PH_HEADER:
            begin
                if (cur_hcount < bmp24_pkg::SIG_END)
                    sig_next = cur_sig | (16'(data_byte) << {cur_hcount[0], 3'b000});
                else if (cur_hcount inside {[bmp24_pkg::WIDTH_POS:bmp24_pkg::HEIGHT_POS - 6'd1]})
                    width_next = cur_width | (32'(data_byte) << {w_off, 3'b000});
                else if (cur_hcount inside {[bmp24_pkg::HEIGHT_POS:bmp24_pkg::FORMAT_POS - 6'd1]})
                    height_next = cur_height | (32'(data_byte) << {h_off, 3'b000});
                else if (cur_hcount inside {[bmp24_pkg::FORMAT_POS:bmp24_pkg::FORMAT_END - 6'd1]})
                    format_next = cur_format | (32'(data_byte) << {f_off, 3'b000});
                hcount_next = cur_hcount + 6'd1;

                if (cur_hcount == bmp24_pkg::HEADER_BYTES - 6'd1)
                begin
                    res_valid = 1'b1;
                    if (sig_next != bmp24_pkg::BMP_SIGNATURE)
                    begin
                        res.kind   = bmp24_pkg::KIND_BAD_SIG;
                        phase_next = bmp24_pkg::PH_IDLE;
                    end
                    else if (format_next != bmp24_pkg::BMP_FORMAT)
                    begin
                        res.kind   = bmp24_pkg::KIND_NOT_24BIT;
                        phase_next = bmp24_pkg::PH_IDLE;
                    end
                    else if (!size_ok(width_next, MAX_WORD) || !size_ok(height_next, MAX_WORD))
                    begin
                        res.kind   = bmp24_pkg::KIND_BAD_SIZE;
                        phase_next = bmp24_pkg::PH_IDLE;
                    end
                    else
                    begin
                        res.kind         = bmp24_pkg::KIND_HEADER_OK;
                        res.image_width  = width_next[12:0];
                        res.image_height = height_next[12:0];
                        phase_next       = bmp24_pkg::PH_PIXEL;
                        bip_next         = 2'd0;
                        col_next         = '0;
                        row_next         = '0;
                        pad_cnt_next     = 2'd0;
                        pad_amt_next     = width_next[1:0];
                    end
                end
            end

            bmp24_pkg::PH_PIXEL:
            begin
                case (bip_reg)
                    2'd0:
                    begin
                        blue_next = data_byte;
                        bip_next  = 2'd1;
                    end
                    2'd1:
                    begin
                        green_next = data_byte;
                        bip_next   = 2'd2;
                    end
                    default:
                    begin
                        bip_next       = 2'd0;
                        res_valid      = 1'b1;
                        res.kind       = bmp24_pkg::KIND_PIXEL;
                        res.row        = row_out[11:0];
                        res.column     = 12'(col_reg);
                        res.blue       = blue_reg;
                        res.green      = green_reg;
                        res.red        = data_byte;
                        res.last_pixel = last;
                        if (last)
                            phase_next = bmp24_pkg::PH_IDLE;
                        else if (row_end)
                        begin
                            col_next     = '0;
                            row_next     = row_reg + CNT_W'(1);
                            pad_cnt_next = 2'd0;
                            if (pad_amt_reg != 2'd0)
                                phase_next = bmp24_pkg::PH_PAD;
                        end
                        else
                            col_next = col_reg + CNT_W'(1);
                    end
                endcase
            end

            bmp24_pkg::PH_PAD:
            begin
                // drop padding bytes up to the row boundary
                pad_cnt_next = pad_inc;
                if (pad_inc >= pad_amt_reg)
                begin
                    pad_cnt_next = 2'd0;
                    phase_next   = bmp24_pkg::PH_PIXEL;
                end
            end

            default:
            begin
                phase_next = cur_phase;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= bmp24_pkg::PH_HEADER;
            hcount_reg  <= '0;
            sig_reg     <= '0;
            width_reg   <= '0;
            height_reg  <= '0;
            format_reg  <= '0;
            bip_reg     <= '0;
            blue_reg    <= '0;
            green_reg   <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            pad_cnt_reg <= '0;
            pad_amt_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            hcount_reg  <= hcount_next;
            sig_reg     <= sig_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            format_reg  <= format_next;
            bip_reg     <= bip_next;
            blue_reg    <= blue_next;
            green_reg   <= green_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            pad_cnt_reg <= pad_cnt_next;
            pad_amt_reg <= pad_amt_next;
        end
    end

endmodule

// ===== sv/bmp24_out_reg.sv =====
// Result register between the parser and the downstream channel.
module bmp24_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic                res_valid,
    input  bmp24_pkg::result_t  res,
    input  logic                result_stall,
    output logic                result_valid,
    output bmp24_pkg::result_t  result
);

    logic               valid_reg, valid_next;
    bmp24_pkg::result_t data_reg;

    // load only happens when the slot is empty or drains this cycle
    assign valid_next = load ? res_valid : (valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load && res_valid)
            data_reg <= res;
    end

    assign result_valid = valid_reg;
    assign result       = data_reg;

endmodule

// ===== sv/bmp24_stream_reader_core.sv =====
// Byte-serial reader for uncompressed 24-bit BMP files.
// Throughput: one byte per cycle; a byte is taken whenever the result register is free
// or drains in the same cycle.
// Results are registered: a result appears in the cycle after the byte that causes it is taken.
// Reset: rst_n clears the parser to the header phase and empties the result register.
module bmp24_stream_reader_core #(
    parameter int MAX_DIM = bmp24_pkg::MAX_DIM_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_stall,
    input  logic [7:0]  data_byte,
    input  logic        file_start,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [2:0]  kind,
    output logic [11:0] row,
    output logic [11:0] column,
    output logic [7:0]  blue,
    output logic [7:0]  green,
    output logic [7:0]  red,
    output logic        last_pixel,
    output logic [12:0] image_width,
    output logic [12:0] image_height
);

    logic               accept;
    logic               res_valid;
    bmp24_pkg::result_t res;
    bmp24_pkg::result_t result;

    // hold input while a finished result is stuck downstream
    assign data_stall = result_valid && result_stall;
    assign accept     = data_valid && !data_stall;

    bmp24_parser #(
        .MAX_DIM (MAX_DIM)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (data_byte),
        .file_start (file_start),
        .res_valid  (res_valid),
        .res        (res)
    );

    bmp24_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (accept),
        .res_valid    (res_valid),
        .res          (res),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result)
    );

    assign kind         = result.kind;
    assign row          = result.row;
    assign column       = result.column;
    assign blue         = result.blue;
    assign green        = result.green;
    assign red          = result.red;
    assign last_pixel   = result.last_pixel;
    assign image_width  = result.image_width;
    assign image_height = result.image_height;

endmodule

// ===== sim/bmp24_result_checker.sv =====
// Checker for the BMP stream reader: tracks accepted bytes, predicts results, compares them.
module bmp24_result_checker
    import bmp24_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    input  logic        data_stall,
    input  logic [7:0]  data_byte,
    input  logic        file_start,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [2:0]  kind,
    input  logic [11:0] row,
    input  logic [11:0] column,
    input  logic [7:0]  blue,
    input  logic [7:0]  green,
    input  logic [7:0]  red,
    input  logic        last_pixel,
    input  logic [12:0] image_width,
    input  logic [12:0] image_height,
    output int          fail_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // Parser image kept by the checker
    phase_t      stage;
    logic [5:0]  hdr_index;
    logic [15:0] sig_acc;
    logic [31:0] width_acc;
    logic [31:0] height_acc;
    logic [31:0] format_acc;
    logic [1:0]  pix_slot;
    logic [7:0]  blue_hold;
    logic [7:0]  green_hold;
    logic [31:0] col_pos;
    logic [31:0] row_pos;
    logic [1:0]  pad_seen;
    logic [1:0]  pad_len;

    result_t awaited_results[$];
    int      mismatches;

    function automatic bit dim_ok(input logic [31:0] v);
        return (v != 32'd0) && (v <= 32'(MAX_DIM));
    endfunction

    task automatic clear_parser();
        stage      = PH_HEADER;
        hdr_index  = '0;
        sig_acc    = '0;
        width_acc  = '0;
        height_acc = '0;
        format_acc = '0;
        pix_slot   = '0;
        blue_hold  = '0;
        green_hold = '0;
        col_pos    = '0;
        row_pos    = '0;
        pad_seen   = '0;
        pad_len    = '0;
    endtask

    // Advance the parser by one byte and queue the result it causes, if any
    task automatic decode_byte(input logic [7:0] b, input logic s);
        result_t r;
        bit      emit;
        bit      row_done;
        bit      image_done;
        r    = '0;
        emit = 1'b0;
        if (s)
            clear_parser();
        case (stage)
            PH_HEADER:
            begin
                if (hdr_index < SIG_END)
                    sig_acc = sig_acc | (16'(b) << (8 * hdr_index));
                else if (hdr_index >= WIDTH_POS && hdr_index < HEIGHT_POS)
                    width_acc = width_acc | (32'(b) << (8 * (hdr_index - WIDTH_POS)));
                else if (hdr_index >= HEIGHT_POS && hdr_index < FORMAT_POS)
                    height_acc = height_acc | (32'(b) << (8 * (hdr_index - HEIGHT_POS)));
                else if (hdr_index >= FORMAT_POS && hdr_index < FORMAT_END)
                    format_acc = format_acc | (32'(b) << (8 * (hdr_index - FORMAT_POS)));
                hdr_index = hdr_index + 6'd1;
                if (hdr_index == HEADER_BYTES)
                begin
                    emit  = 1'b1;
                    stage = PH_IDLE;
                    if (sig_acc != BMP_SIGNATURE)
                        r.kind = KIND_BAD_SIG;
                    else if (format_acc != BMP_FORMAT)
                        r.kind = KIND_NOT_24BIT;
                    else if (!dim_ok(width_acc) || !dim_ok(height_acc))
                        r.kind = KIND_BAD_SIZE;
                    else
                    begin
                        r.kind         = KIND_HEADER_OK;
                        r.image_width  = width_acc[12:0];
                        r.image_height = height_acc[12:0];
                        stage          = PH_PIXEL;
                        pix_slot       = '0;
                        col_pos        = '0;
                        row_pos        = '0;
                        pad_seen       = '0;
                        pad_len        = width_acc[1:0];
                    end
                end
            end
            PH_PIXEL:
            begin
                if (pix_slot == 2'd0)
                begin
                    blue_hold = b;
                    pix_slot  = 2'd1;
                end
                else if (pix_slot == 2'd1)
                begin
                    green_hold = b;
                    pix_slot   = 2'd2;
                end
                else
                begin
                    pix_slot     = 2'd0;
                    row_done     = (col_pos + 32'd1 >= width_acc);
                    image_done   = row_done && (row_pos + 32'd1 >= height_acc);
                    emit         = 1'b1;
                    r.kind       = KIND_PIXEL;
                    // Rows arrive bottom-up
                    r.row        = 12'(height_acc - 32'd1 - row_pos);
                    r.column     = col_pos[11:0];
                    r.blue       = blue_hold;
                    r.green      = green_hold;
                    r.red        = b;
                    r.last_pixel = image_done;
                    if (image_done)
                        stage = PH_IDLE;
                    else if (row_done)
                    begin
                        col_pos  = '0;
                        row_pos  = row_pos + 32'd1;
                        pad_seen = '0;
                        if (pad_len != 2'd0)
                            stage = PH_PAD;
                    end
                    else
                        col_pos = col_pos + 32'd1;
                end
            end
            PH_PAD:
            begin
                pad_seen = pad_seen + 2'd1;
                if (pad_seen >= pad_len)
                begin
                    pad_seen = '0;
                    stage    = PH_PIXEL;
                end
            end
            default:
            begin
            end
        endcase
        if (emit)
            awaited_results.push_back(r);
    endtask

    task automatic note_mismatch(input string what, input logic [12:0] want_v,
                                 input logic [12:0] got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $realtime, what,
                     want_v, got_v);
    endtask

    task automatic compare_result();
        result_t want;
        if (awaited_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t ns: unexpected result, kind %0d", $realtime, kind);
            return;
        end
        want = awaited_results.pop_front();
        if (13'(want.kind) !== 13'(kind))
            note_mismatch("kind", 13'(want.kind), 13'(kind));
        if (want.row !== row)
            note_mismatch("row", 13'(want.row), 13'(row));
        if (want.column !== column)
            note_mismatch("column", 13'(want.column), 13'(column));
        if (want.blue !== blue)
            note_mismatch("blue", 13'(want.blue), 13'(blue));
        if (want.green !== green)
            note_mismatch("green", 13'(want.green), 13'(green));
        if (want.red !== red)
            note_mismatch("red", 13'(want.red), 13'(red));
        if (want.last_pixel !== last_pixel)
            note_mismatch("last_pixel", 13'(want.last_pixel), 13'(last_pixel));
        if (want.image_width !== image_width)
            note_mismatch("image_width", want.image_width, image_width);
        if (want.image_height !== image_height)
            note_mismatch("image_height", want.image_height, image_height);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parser();
            awaited_results.delete();
            mismatches    = 0;
            fail_count    <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (data_valid && !data_stall)
                decode_byte(data_byte, file_start);
            if (result_valid && !result_stall)
                compare_result();
            fail_count    <= mismatches;
            pending_count <= awaited_results.size();
        end
    end

endmodule

// ===== sim/bmp24_stream_reader_core_tb.sv =====
// Testbench top for the BMP stream reader: clock, reset, byte stimulus and verdict.
module bmp24_stream_reader_core_tb;
    import bmp24_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        data_valid   = 1'b0;
    logic        data_stall;
    logic [7:0]  data_byte    = 8'd0;
    logic        file_start   = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [2:0]  kind;
    logic [11:0] row;
    logic [11:0] column;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic        last_pixel;
    logic [12:0] image_width;
    logic [12:0] image_height;

    int fail_count;
    int pending_count;
    int bytes_sent = 0;
    int cut_left   = -1;
    bit steady     = 1'b0;

    bmp24_stream_reader_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_valid   (data_valid),
        .data_stall   (data_stall),
        .data_byte    (data_byte),
        .file_start   (file_start),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .kind         (kind),
        .row          (row),
        .column       (column),
        .blue         (blue),
        .green        (green),
        .red          (red),
        .last_pixel   (last_pixel),
        .image_width  (image_width),
        .image_height (image_height)
    );

    bmp24_result_checker u_result_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_valid    (data_valid),
        .data_stall    (data_stall),
        .data_byte     (data_byte),
        .file_start    (file_start),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .kind          (kind),
        .row           (row),
        .column        (column),
        .blue          (blue),
        .green         (green),
        .red           (red),
        .last_pixel    (last_pixel),
        .image_width   (image_width),
        .image_height  (image_height),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
            result_stall <= !steady && ($urandom_range(99) < 37);
    end

    initial
    begin
        #4_000_000;
        $display("bmp24_stream_reader_core_tb NOT OK");
        $finish;
    end

    // Offer one byte and hold it until the transfer happens
    task automatic put_byte(input logic [7:0] b, input logic s);
        if (cut_left == 0)
            return;
        if (cut_left > 0)
            cut_left--;
        while (!steady && $urandom_range(99) < 37)
        begin
            data_valid <= 1'b0;
            @(posedge clk);
        end
        data_valid <= 1'b1;
        data_byte  <= b;
        file_start <= s;
        do @(posedge clk); while (data_stall);
        bytes_sent++;
    endtask

    // Send one file: header, optional pixel rows with padding, then trailing bytes
    task automatic send_bmp(input logic [31:0] w, input logic [31:0] h,
                            input logic [15:0] sig, input logic [31:0] fmt,
                            input bit mark_start, input bit with_pixels,
                            input int stop_after, input int tail_bytes);
        logic [7:0] b;
        cut_left = stop_after;
        for (int i = 0; i < 54; i++)
        begin
            if (i < 2)
                b = sig[8*i +: 8];
            else if (i >= 18 && i < 22)
                b = w[8*(i-18) +: 8];
            else if (i >= 22 && i < 26)
                b = h[8*(i-22) +: 8];
            else if (i >= 26 && i < 30)
                b = fmt[8*(i-26) +: 8];
            else
                b = 8'($urandom);
            put_byte(b, (i == 0) && mark_start);
        end
        if (with_pixels)
        begin
            for (int r = 0; r < int'(h); r++)
            begin
                for (int k = 0; k < 3 * int'(w) + int'(w[1:0]); k++)
                    put_byte(8'($urandom), 1'b0);
            end
        end
        for (int t = 0; t < tail_bytes; t++)
            put_byte(8'($urandom), 1'b0);
        cut_left = -1;
    endtask

    task automatic drain();
        data_valid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
    endtask

    initial
    begin
        int          files_done;
        int          pick;
        logic [31:0] w;
        logic [31:0] h;
        logic [15:0] sig;
        logic [31:0] fmt;
        bit          body;
        int          stop_at;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // First file without a start flag: parse from byte 0 after reset
        send_bmp(2, 2, BMP_SIGNATURE, BMP_FORMAT, 1'b0, 1'b1, -1, 5);
        // Padding of 3, 0, 1 bytes per row
        send_bmp(3, 2, BMP_SIGNATURE, BMP_FORMAT, 1'b1, 1'b1, -1, 0);
        send_bmp(4, 1, BMP_SIGNATURE, BMP_FORMAT, 1'b1, 1'b1, -1, 0);
        send_bmp(5, 1, BMP_SIGNATURE, BMP_FORMAT, 1'b1, 1'b1, -1, 2);
        // Errors: bytes after them are ignored until a new start
        send_bmp(2, 2, 16'h4D43, BMP_FORMAT, 1'b1, 1'b0, -1, 6);
        send_bmp(0, 1, BMP_SIGNATURE, 32'h0020_0001, 1'b1, 1'b0, -1, 3);
        send_bmp(1, 32'hFFFF_FFFF, BMP_SIGNATURE, BMP_FORMAT, 1'b1, 1'b0, -1, 2);
        // Restart in the middle of a header
        send_bmp(2, 2, BMP_SIGNATURE, BMP_FORMAT, 1'b1, 1'b1, 20, 0);
        // Largest width, restarted after two pixels
        send_bmp(4096, 1, BMP_SIGNATURE, BMP_FORMAT, 1'b1, 1'b1, 60, 0);

        // Hold off until every outstanding result has come back
        drain();

        files_done = 0;
        while (bytes_sent < 650)
        begin
            pick    = $urandom_range(99);
            w       = $urandom_range(1, 6);
            h       = $urandom_range(1, 3);
            sig     = BMP_SIGNATURE;
            fmt     = BMP_FORMAT;
            body    = 1'b1;
            stop_at = -1;
            if (pick < 7)
            begin
                sig  = sig ^ (16'd1 << $urandom_range(15));
                body = 1'b0;
            end
            else if (pick < 14)
            begin
                fmt  = fmt ^ (32'd1 << $urandom_range(31));
                body = 1'b0;
            end
            else if (pick < 20)
            begin
                case ($urandom_range(3))
                    0: w = 0;
                    1: h = 0;
                    2: w = 4097 + $urandom_range(0, 5000);
                    default: h = $urandom;
                endcase
                body = 1'b0;
            end
            else if (pick < 28)
                stop_at = $urandom_range(1, 54 + 3 * int'(w) * int'(h));
            else if (pick < 32)
            begin
                // Noise: random signature and format words
                sig  = 16'($urandom);
                fmt  = $urandom;
                body = 1'b0;
            end
            steady = (files_done < 3);
            send_bmp(w, h, sig, fmt, 1'b1, body, stop_at, $urandom_range(0, 2));
            steady = 1'b0;
            files_done++;
        end

        drain();
        repeat (5) @(posedge clk);
        if (fail_count == 0)
            $display("bmp24_stream_reader_core_tb OK");
        else
            $display("bmp24_stream_reader_core_tb NOT OK");
        $finish;
    end

endmodule
